// ===== hdl/accel_magnitude_moving_average_defines.svh =====
// assertion macros shared by the accel magnitude moving average rtl
`ifndef ACCEL_MAGNITUDE_MOVING_AVERAGE_DEFINES_SVH
`define ACCEL_MAGNITUDE_MOVING_AVERAGE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define AMMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("amma: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define AMMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("amma: next-cycle check failed");

`endif

// ===== hdl/amma_pkg.sv =====
// shared types, constants and helpers of the accel magnitude moving average
`timescale 1ns / 1ps
`default_nettype none

package amma_pkg;

	// field widths
	localparam int unsigned AXIS_W     = 16;
	localparam int unsigned MAG_W      = 16;
	localparam int unsigned SUM_W      = 22;
	localparam int unsigned SQ_W       = 32;
	localparam int unsigned IN_DATA_W  = 3 * AXIS_W;
	localparam int unsigned OUT_DATA_W = 2 * MAG_W;

	// default averaging window
	localparam int unsigned WINDOW_DEF = 10;

	// root unit schedule: three squares through the multiplier, then one root step per cycle
	localparam int unsigned CNT_W      = 5;
	localparam logic [CNT_W-1:0] SQ_CYCLES  = 5'd3;
	localparam logic [CNT_W-1:0] ROOT_STEPS = 5'd16;
	localparam logic [CNT_W-1:0] ROOT_LAST  = SQ_CYCLES + ROOT_STEPS;
	localparam logic [SQ_W-1:0]  ROOT_BIT_INIT = 32'h4000_0000;

	// top level sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_AVG,
		ST_LOAD
	} amma_state_t;

	// status of an iterative unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	// magnitude of a two's complement count, -32768 maps to 32768
	function automatic logic [AXIS_W-1:0] abs_axis(input logic [AXIS_W-1:0] v);
		logic [AXIS_W-1:0] r;
		r = v[AXIS_W-1] ? (~v + AXIS_W'(1)) : v;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/amma_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module amma_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 10,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/amma_root.sv =====
// sum of squares and bit-pair integer square root on one shared step unit
`timescale 1ns / 1ps
`default_nettype none

module amma_root import amma_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [AXIS_W-1:0] ax,
	input  wire logic [AXIS_W-1:0] ay,
	input  wire logic [AXIS_W-1:0] az,
	output logic      [MAG_W-1:0]  magnitude,
	output unit_sts_t              sts
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	logic [AXIS_W-1:0] abs_q [3];
	logic [SQ_W-1:0]   prod_s1;
	logic [SQ_W-1:0]   rem_q;
	logic [SQ_W-1:0]   root_q;
	logic [SQ_W-1:0]   bit_q;

	logic [SQ_W:0] trial;
	logic          take;

	// sequencing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == ROOT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// root step: compare remainder against root plus current bit
	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign take  = ({1'b0, rem_q} >= trial);

	// datapath: squares through one multiplier, then 16 root steps
	always_ff @(posedge clk) begin
		if (start) begin
			abs_q[0] <= abs_axis(ax);
			abs_q[1] <= abs_axis(ay);
			abs_q[2] <= abs_axis(az);
			rem_q    <= '0;
			root_q   <= '0;
			bit_q    <= ROOT_BIT_INIT;
		end else if (busy_q) begin
			if (cnt_q < SQ_CYCLES) begin
				prod_s1  <= {16'b0, abs_q[0]} * {16'b0, abs_q[0]};
				abs_q[0] <= abs_q[1];
				abs_q[1] <= abs_q[2];
			end
			if ((cnt_q != '0) && (cnt_q <= SQ_CYCLES)) begin
				rem_q <= rem_q + prod_s1;
			end
			if (cnt_q > SQ_CYCLES) begin
				if (take) begin
					rem_q  <= rem_q - trial[SQ_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	assign magnitude = root_q[MAG_W-1:0];
	assign sts.busy  = busy_q;
	assign sts.done  = done_q;

endmodule

`default_nettype wire

// ===== hdl/amma_avg.sv =====
// history ring, running sum and reciprocal-multiply mean
`timescale 1ns / 1ps
`default_nettype none

module amma_avg import amma_pkg::*; #(
	parameter int unsigned WINDOW = WINDOW_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [MAG_W-1:0] mag_in,
	output logic      [MAG_W-1:0] mean,
	output unit_sts_t             sts
);

	localparam int unsigned SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned WIN_W   = $clog2(WINDOW + 1);
	localparam int unsigned RECIP_W = SUM_W + 1;
	localparam int unsigned PROD_W  = SUM_W + RECIP_W;
	localparam int unsigned FIX_W   = MAG_W + 1 + WIN_W;
	localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((64'd1 << SUM_W) / WINDOW);
	localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(WINDOW - 1);
	localparam logic [FIX_W-1:0]   WIN_F     = FIX_W'(WINDOW);

	// phases of one update
	localparam logic [2:0] PH_READ   = 3'd0;
	localparam logic [2:0] PH_UPDATE = 3'd1;
	localparam logic [2:0] PH_MUL    = 3'd2;
	localparam logic [2:0] PH_EST    = 3'd3;
	localparam logic [2:0] PH_FIX    = 3'd4;

	logic              busy_q;
	logic              done_q;
	logic [2:0]        ph_q;
	logic [SLOT_W-1:0] slot_q;
	logic [WINDOW-1:0] valid_q;
	logic [SUM_W-1:0]  sum_q;

	logic [MAG_W-1:0]  mag_q;
	logic [PROD_W-1:0] prod_s1;
	logic [MAG_W-1:0]  qest_s2;
	logic [MAG_W-1:0]  mean_q;

	logic [MAG_W-1:0] ring_rdata;
	logic [MAG_W-1:0] old_mag;
	logic             ring_we;
	logic [MAG_W:0]   q_inc;
	logic [FIX_W-1:0] q_mul;

	// ring storage
	amma_ram #(
		.WIDTH (MAG_W),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (slot_q),
		.wdata (mag_q),
		.raddr (slot_q),
		.rdata (ring_rdata)
	);

	// entries never written read as zero
	assign old_mag = valid_q[slot_q] ? ring_rdata : '0;
	assign ring_we = busy_q && (ph_q == PH_UPDATE);

	// correction of the reciprocal estimate
	assign q_inc = {1'b0, qest_s2} + (MAG_W + 1)'(1);
	assign q_mul = FIX_W'(q_inc) * WIN_F;

	// phase control, slot pointer, valid bits and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			ph_q    <= PH_READ;
			slot_q  <= '0;
			valid_q <= '0;
			sum_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= PH_READ;
			end else if (busy_q) begin
				ph_q <= ph_q + 3'd1;
				if (ph_q == PH_UPDATE) begin
					sum_q           <= sum_q - SUM_W'(old_mag) + SUM_W'(mag_q);
					valid_q[slot_q] <= 1'b1;
					slot_q          <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
				end
				if (ph_q == PH_FIX) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// mean datapath
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag_in;
		end
		if (busy_q && (ph_q == PH_MUL)) begin
			prod_s1 <= PROD_W'(sum_q) * PROD_W'(RECIP);
		end
		if (busy_q && (ph_q == PH_EST)) begin
			qest_s2 <= prod_s1[SUM_W +: MAG_W];
		end
		if (busy_q && (ph_q == PH_FIX)) begin
			mean_q <= (q_mul <= FIX_W'(sum_q)) ? q_inc[MAG_W-1:0] : qest_s2;
		end
	end

	assign mean     = mean_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

`default_nettype wire

// ===== hdl/accel_magnitude_moving_average.sv =====
// top level: accelerometer magnitude with boxcar moving average
//
// usage:
//   s_axis carries one three-axis sample per transfer, signed 16-bit counts.
//   m_axis returns one result per sample: the floored square root of
//   x*x + y*y + z*z and the mean of the last WINDOW magnitudes, truncated.
//   processing: the squares share one 16x16 multiplier, the root runs one
//   bit pair per cycle over 16 steps, then the window unit updates the
//   ring and forms the reciprocal mean in five phases (read, update,
//   multiply, estimate, fix), with handoff between the units.
//   a new sample is not taken until the previous one has passed through;
//   s_axis_tready is high only while the sequencer is idle.
//   the output register holds a finished result, so a new sample is taken
//   while the previous result waits; if the receiver stalls longer the
//   next result waits inside and the block stays busy until it is taken.
//   reset: arst_n clears the ring's valid bits (all entries read as zero), the slot
//   pointer and the running sum, so the first means average in zeros.
`timescale 1ns / 1ps
`default_nettype none
`include "accel_magnitude_moving_average_defines.svh"

module accel_magnitude_moving_average import amma_pkg::*; #(
	parameter int unsigned WINDOW = WINDOW_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // accel_x, accel_y, accel_z
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [OUT_DATA_W-1:0] m_axis_tdata   // magnitude, filtered_magnitude
);

	amma_state_t state_q;
	amma_state_t state_d;

	unit_sts_t root_sts;
	unit_sts_t avg_sts;

	logic             start_root;
	logic             start_avg;
	logic             load_out;
	logic             out_free;
	logic [MAG_W-1:0] magnitude;
	logic [MAG_W-1:0] filtered_magnitude;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// magnitude unit
	amma_root u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_root),
		.ax        (s_axis_tdata[0 +: AXIS_W]),
		.ay        (s_axis_tdata[AXIS_W +: AXIS_W]),
		.az        (s_axis_tdata[2*AXIS_W +: AXIS_W]),
		.magnitude (magnitude),
		.sts       (root_sts)
	);

	// window unit
	amma_avg #(
		.WINDOW (WINDOW)
	) u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_avg),
		.mag_in (magnitude),
		.mean   (filtered_magnitude),
		.sts    (avg_sts)
	);

	assign out_free = !out_valid_q || m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (root_sts.done) begin
					state_d = ST_AVG;
				end
			end
			ST_AVG: begin
				if (avg_sts.done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		start_root    = 1'b0;
		start_avg     = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				start_root    = s_axis_tvalid;
			end
			ST_ROOT: begin
				start_avg = root_sts.done;
			end
			ST_AVG: begin
			end
			ST_LOAD: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register data
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {filtered_magnitude, magnitude};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// checks on the sequencer and its units
	`AMMA_ASSERT_NEXT(a_accept_starts_root, clk, arst_n, s_axis_tvalid && s_axis_tready, (state_q == ST_ROOT) && root_sts.busy)
	`AMMA_ASSERT_SAME(a_root_done_in_root, clk, arst_n, root_sts.done, state_q == ST_ROOT)
	`AMMA_ASSERT_SAME(a_avg_done_in_avg, clk, arst_n, avg_sts.done, state_q == ST_AVG)
	`AMMA_ASSERT_SAME(a_idle_units_quiet, clk, arst_n, state_q == ST_IDLE, !root_sts.busy && !avg_sts.busy)

endmodule

`default_nettype wire

// ===== test/accel_magnitude_moving_average_tb.sv =====
// testbench for the accelerometer magnitude moving average, with its own predictor
`timescale 1ns / 1ps

module accel_magnitude_moving_average_tb;
	import amma_pkg::*;

	localparam int unsigned WINDOW       = WINDOW_DEF;
	localparam int          NUM_DIRECTED = 20;
	localparam int          NUM_RANDOM   = 1130;
	localparam int          CALM_FIRST   = 500;
	localparam int          CALM_LAST    = 700;
	localparam int          CYCLE_LIMIT  = 600000;
	localparam int          DRAIN_CYCLES = 40;

	// one sample, x in the lowest bits
	typedef struct packed {
		logic signed [AXIS_W-1:0] z;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] x;
	} sample_t;

	// one result, magnitude in the lowest bits
	typedef struct packed {
		logic [MAG_W-1:0] filt;
		logic [MAG_W-1:0] mag;
	} result_t;

	// directed stimulus row; typed marks a hand-written expected result
	typedef struct packed {
		sample_t smp;
		logic    typed;
		result_t res;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // accel_x, accel_y, accel_z
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;       // magnitude, filtered_magnitude

	// predictor state
	logic [MAG_W-1:0] history [WINDOW];
	int unsigned      slot_ptr;
	logic [SUM_W-1:0] window_total;

	result_t   pending [$];
	plan_row_t plan [NUM_DIRECTED];
	int        errors = 0;
	int        sent = 0;
	int        checked = 0;
	int        cycles = 0;
	bit        calm = 1'b0;

	accel_magnitude_moving_average #(
		.WINDOW(WINDOW)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// floor square root, one result bit at a time from the top
	function automatic logic [MAG_W-1:0] root_floor(input logic [33:0] n);
		logic [MAG_W-1:0] r;
		logic [MAG_W-1:0] t;
		r = '0;
		for (int b = MAG_W - 1; b >= 0; b--) begin
			t = r | (MAG_W'(1) << b);
			if (34'(t) * 34'(t) <= n)
				r = t;
		end
		return r;
	endfunction

	// magnitude of a sample, then ring and running sum update
	function automatic result_t predict_sample(input sample_t s);
		longint           energy;
		int               xs, ys, zs;
		logic [MAG_W-1:0] m;
		result_t          r;
		xs = s.x;
		ys = s.y;
		zs = s.z;
		energy = longint'(xs) * xs + longint'(ys) * ys + longint'(zs) * zs;
		m = root_floor(34'(energy));
		window_total = window_total - SUM_W'(history[slot_ptr]) + SUM_W'(m);
		history[slot_ptr] = m;
		slot_ptr = (slot_ptr == WINDOW - 1) ? 0 : slot_ptr + 1;
		r.mag = m;
		r.filt = MAG_W'(window_total / WINDOW);
		return r;
	endfunction

	// one axis value for the random part
	function automatic logic signed [AXIS_W-1:0] pick_axis(input int mode);
		logic signed [AXIS_W-1:0] v;
		case (mode)
			0: v = AXIS_W'($urandom);
			1: v = AXIS_W'($signed($urandom_range(0, 511)) - 256);
			default: begin
				case ($urandom_range(0, 5))
					0: v = -16'sd32768;
					1: v = -16'sd32767;
					2: v = -16'sd1;
					3: v = 16'sd0;
					4: v = 16'sd1;
					default: v = 16'sd32767;
				endcase
			end
		endcase
		return v;
	endfunction

	// drive one sample until its transfer, record the expected result, and outside the calm stretch sometimes pause
	task automatic send_sample(input sample_t smp, input logic typed, input result_t typed_res);
		result_t calc;
		s_axis_tdata <= smp;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		calc = predict_sample(smp);
		pending.push_back(typed ? typed_res : calc);
		sent++;
		if (!calm && $urandom_range(0, 99) < 11) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	endtask

	// directed rows: after reset, extremes, wrap of the ring
	initial begin
		plan[0]  = '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd0, 16'd0}};
		plan[1]  = '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b1, '{16'd5675, 16'd56755}};
		plan[2]  = '{'{16'sd0, 16'sd0, 16'sd32767}, 1'b1, '{16'd8952, 16'd32767}};
		plan[3]  = '{'{16'sd0, -16'sd32768, 16'sd0}, 1'b1, '{16'd12229, 16'd32768}};
		plan[4]  = '{'{-16'sd1, 16'sd0, 16'sd0}, 1'b1, '{16'd12229, 16'd1}};
		plan[5]  = '{'{16'sd0, 16'sd4, 16'sd3}, 1'b0, '0};
		plan[6]  = '{'{16'sd1, 16'sd1, 16'sd1}, 1'b0, '0};
		plan[7]  = '{'{-16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, '0};
		plan[8]  = '{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0};
		plan[9]  = '{'{-16'sd1, -16'sd1, -16'sd1}, 1'b0, '0};
		plan[10] = '{'{16'sd21845, -16'sd21846, 16'sd21845}, 1'b0, '0};
		plan[11] = '{'{-16'sd21846, 16'sd21845, -16'sd21846}, 1'b0, '0};
		plan[12] = '{'{16'sd21, 16'sd16, 16'sd12}, 1'b0, '0};
		plan[13] = '{'{16'sd0, 16'sd2, 16'sd2}, 1'b0, '0};
		plan[14] = '{'{-16'sd32767, 16'sd0, 16'sd0}, 1'b0, '0};
		plan[15] = '{'{16'sd0, 16'sd0, 16'sd0}, 1'b0, '0};
		plan[16] = '{'{16'sd256, -16'sd255, 16'sd128}, 1'b0, '0};
		plan[17] = '{'{-16'sd32768, 16'sd0, 16'sd32767}, 1'b0, '0};
		plan[18] = '{'{16'sd4660, -16'sd4661, 16'sd30000}, 1'b0, '0};
		plan[19] = '{'{16'sd0, 16'sd0, 16'sd0}, 1'b0, '0};
	end

	// reset, directed rows, random samples, drain and verdict
	initial begin
		sample_t smp;
		int      mode;
		for (int i = 0; i < WINDOW; i++)
			history[i] = '0;
		slot_ptr = 0;
		window_total = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int k = 0; k < NUM_DIRECTED; k++)
			send_sample(plan[k].smp, plan[k].typed, plan[k].res);
		for (int k = 0; k < NUM_RANDOM; k++) begin
			calm = (k >= CALM_FIRST && k < CALM_LAST);
			mode = $urandom_range(0, 99);
			mode = (mode < 60) ? 0 : (mode < 80) ? 1 : 2;
			smp.x = pick_axis(mode);
			smp.y = pick_axis(mode);
			smp.z = pick_axis(mode);
			send_sample(smp, 1'b0, '0);
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d samples (%0d directed, %0d random), %0d results checked",
			sent, NUM_DIRECTED, NUM_RANDOM, checked);
		$display("errors: %0d", errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// receiver readiness with random stalls
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 11);
	end

	// compare each result transfer with the oldest expected result
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result mag %0d filt %0d", $time, got.mag, got.filt);
			end else begin
				want = pending.pop_front();
				checked++;
				if (got.mag !== want.mag) begin
					errors++;
					$display("%0t: magnitude expected %0d actual %0d",
						$time, want.mag, got.mag);
				end
				if (got.filt !== want.filt) begin
					errors++;
					$display("%0t: filtered magnitude expected %0d actual %0d",
						$time, want.filt, got.filt);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending.size());
			$display("FAIL");
			$finish;
		end
	end

endmodule
